// File: design/mtam_pkg.sv
// ----------------------------------------------------------------------------
// mtam_pkg: shared types and constants of the multitrack audio mixer
// Opcodes, register indexes, request/result structs and the per-track
// contribution carried down the cell chain.
// ----------------------------------------------------------------------------
package mtam_pkg;

	localparam int TRACKS           = 4;
	localparam int FRAMES_PER_TRACK = 4096;
	localparam int MAX_OUT_CHANNELS = 8;
	localparam int TW   = $clog2(TRACKS);
	localparam int FW   = $clog2(FRAMES_PER_TRACK);
	localparam int LW   = FW + 1;
	localparam int AW   = TW + FW;
	localparam int CW   = $clog2(MAX_OUT_CHANNELS);
	localparam int NCW  = CW + 1;
	localparam int ACCW = 20;
	localparam logic [16:0] UNITY = 17'd32768;

	localparam logic [2:0] OP_LOAD   = 3'd0;
	localparam logic [2:0] OP_LENGTH = 3'd1;
	localparam logic [2:0] OP_PLAY   = 3'd2;
	localparam logic [2:0] OP_PAUSE  = 3'd3;
	localparam logic [2:0] OP_REWIND = 3'd4;
	localparam logic [2:0] OP_RENDER = 3'd5;

	localparam logic [2:0] REG_MUTE   = 3'd4;
	localparam logic [2:0] REG_STEREO = 3'd5;
	localparam logic [2:0] REG_NCH    = 3'd6;
	localparam logic [2:0] REG_NONE   = 3'd7;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [1:0]         track;
		logic [11:0]        frame_index;
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic [12:0]        length;
	} req_t;

	typedef struct packed {
		logic [2:0]         channel_index;
		logic signed [15:0] mixed_sample;
		logic               last;
		logic [3:0]         playing_mask;
	} res_t;

	// contribution of one track to the frame
	typedef struct packed {
		logic               en;
		logic               stereo;
		logic signed [16:0] l;
		logic signed [16:0] r;
	} contrib_t;

endpackage

// File: design/mtam_ram.sv
// ----------------------------------------------------------------------------
// mtam_ram: generic single-port RAM with registered read
// One write or one read per cycle.
// ----------------------------------------------------------------------------
module mtam_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write or read one word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// File: design/mtam_cell.sv
// ----------------------------------------------------------------------------
// mtam_cell: one channel accumulator of the mix chain
// Adds each passing track contribution to its own sum and hands the
// contribution on to the next channel cell.
// ----------------------------------------------------------------------------
module mtam_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              clr,
	input  logic [mtam_pkg::CW-1:0]           chan,
	input  logic [mtam_pkg::NCW-1:0]          nch,
	input  mtam_pkg::contrib_t                cin,
	output mtam_pkg::contrib_t                cout,
	output logic signed [mtam_pkg::ACCW-1:0]  sum
);
	logic signed [16:0] add;
	logic signed [17:0] lr;
	logic signed [mtam_pkg::ACCW-1:0] sum_q;

	// select this channel's share
	always_comb begin
		lr = 18'(cin.l) + 18'(cin.r);
		if (!cin.stereo) begin
			add = cin.l;
		end else if (nch == mtam_pkg::NCW'(1)) begin
			add = 17'(lr >>> 1);
		end else if (chan == mtam_pkg::CW'(0)) begin
			add = cin.l;
		end else if (chan == mtam_pkg::CW'(1)) begin
			add = cin.r;
		end else begin
			add = 17'(lr >>> 1);
		end
	end

	// accumulate and pass the contribution along
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			cout   <= '0;
		end else begin
			cout <= cin;
			if (clr) begin
				sum_q <= '0;
			end else if (cin.en) begin
				sum_q <= sum_q + mtam_pkg::ACCW'(add);
			end
		end
	end
	assign sum = sum_q;
endmodule

// File: design/multitrack_audio_mixer_top.sv
// ----------------------------------------------------------------------------
// multitrack_audio_mixer_top: four-track PCM mixer with gain and upmix
// Stores tracks in a sample RAM, walks the tracks one per cycle through a
// scaler, and accumulates in a chain of eight channel cells.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_ready  | in_data  (mtam_pkg::req_t)
//  out     | out_valid/out_ready| out_data (mtam_pkg::res_t)
//  config  | cfg_we             | cfg_index, cfg_data
//
// A render walks the tracks (one RAM read per track) and drains the chain,
// then presents one output channel per cycle, stalled by out_ready. Reset
// clears all track state; the sample RAM is not cleared. One request is in
// work at a time.
module multitrack_audio_mixer_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mtam_pkg::req_t     in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output mtam_pkg::res_t     out_data,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	localparam int T = mtam_pkg::TRACKS;
	localparam int M = mtam_pkg::MAX_OUT_CHANNELS;
	localparam int DRAIN = M + 3;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_WALK = 4'b0010,
		S_WAIT = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [15:0] gain_q [4];
	logic [3:0]  mute_q, stereo_q, ncfg_q;
	logic [mtam_pkg::LW-1:0] len_q [T];
	logic [mtam_pkg::LW-1:0] pos_q [T];
	logic [T-1:0] play_q;
	logic run_q;
	logic [mtam_pkg::TW:0] trk_q;
	logic [4:0] wait_q;
	logic [mtam_pkg::CW-1:0] oc_q;
	logic [mtam_pkg::NCW-1:0] nch;
	logic acc;

	// read stage: selected track walking
	logic [mtam_pkg::TW-1:0] ti;
	logic hit;
	logic [mtam_pkg::AW-1:0] ram_addr;
	logic ram_we;
	logic [31:0] ram_rd;
	logic hit_s1, st_s1;
	logic [16:0] g_s1;
	logic signed [32:0] pl_s2, pr_s2;
	logic hit_s2, st_s2;
	mtam_pkg::contrib_t c0;
	mtam_pkg::contrib_t cc [M+1];
	logic signed [mtam_pkg::ACCW-1:0] sums [M];
	logic clr;

	assign acc = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign ti = trk_q[mtam_pkg::TW-1:0];

	// clamp the channel count
	always_comb begin
		if (ncfg_q == 4'd0) nch = mtam_pkg::NCW'(1);
		else if (32'(ncfg_q) > M) nch = mtam_pkg::NCW'(M);
		else nch = mtam_pkg::NCW'(ncfg_q);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) gain_q[i] <= 16'd32768;
			mute_q <= '0; stereo_q <= '0; ncfg_q <= 4'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mtam_pkg::REG_MUTE:   mute_q   <= cfg_data[3:0];
				mtam_pkg::REG_STEREO: stereo_q <= cfg_data[3:0];
				mtam_pkg::REG_NCH:    ncfg_q   <= cfg_data[3:0];
				mtam_pkg::REG_NONE: ;
				default: gain_q[cfg_index[1:0]] <= cfg_data;
			endcase
		end
	end

	// decide whether the walked track contributes; pick RAM address and write enable
	always_comb begin
		hit = (state_q == S_WALK) && run_q && len_q[ti] != '0 && play_q[ti]
			&& !mute_q[ti] && pos_q[ti] < len_q[ti];
		ram_we = acc && in_data.opcode == mtam_pkg::OP_LOAD;
		if (state_q == S_WALK) ram_addr = {ti, pos_q[ti][mtam_pkg::FW-1:0]};
		else ram_addr = {in_data.track, in_data.frame_index};
	end

	mtam_ram #(.WIDTH(32), .DEPTH(T * mtam_pkg::FRAMES_PER_TRACK)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr),
		.wdata({in_data.right_sample, in_data.left_sample}), .rdata(ram_rd)
	);

	// control and track state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; run_q <= 1'b0; play_q <= '0;
			trk_q <= '0; wait_q <= '0; oc_q <= '0;
			for (int i = 0; i < T; i++) begin len_q[i] <= '0; pos_q[i] <= '0; end
		end else begin
			unique case (state_q)
				S_IDLE: if (acc) begin
					case (in_data.opcode)
						mtam_pkg::OP_LENGTH: begin
							len_q[in_data.track] <=
								(in_data.length > 13'(mtam_pkg::FRAMES_PER_TRACK))
								? mtam_pkg::LW'(mtam_pkg::FRAMES_PER_TRACK)
								: in_data.length;
							pos_q[in_data.track] <= '0;
							if (in_data.length == '0) play_q[in_data.track] <= 1'b0;
						end
						mtam_pkg::OP_PLAY: begin
							for (int i = 0; i < T; i++)
								if (len_q[i] != '0) play_q[i] <= 1'b1;
							run_q <= 1'b1;
						end
						mtam_pkg::OP_PAUSE: run_q <= 1'b0;
						mtam_pkg::OP_REWIND: begin
							run_q <= 1'b0; play_q <= '0;
							for (int i = 0; i < T; i++) pos_q[i] <= '0;
						end
						mtam_pkg::OP_RENDER: begin
							state_q <= S_WALK; trk_q <= '0;
						end
						default: ;
					endcase
				end
				S_WALK: begin
					if (run_q && play_q[ti] && !mute_q[ti] && len_q[ti] != '0) begin
						if (hit) begin
							pos_q[ti] <= pos_q[ti] + 1'b1;
							if (pos_q[ti] + 1'b1 >= len_q[ti]) play_q[ti] <= 1'b0;
						end else begin
							play_q[ti] <= 1'b0;
						end
					end
					if (32'(trk_q) == T - 1) begin
						state_q <= S_WAIT; wait_q <= '0;
					end
					trk_q <= trk_q + 1'b1;
				end
				S_WAIT: begin
					wait_q <= wait_q + 1'b1;
					if (32'(wait_q) == DRAIN) begin
						state_q <= S_OUT; oc_q <= '0;
					end
				end
				S_OUT: if (out_ready) begin
					oc_q <= oc_q + 1'b1;
					if (mtam_pkg::NCW'(oc_q) + 1'b1 == nch) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// scale pipeline: register read, then multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0; hit_s2 <= 1'b0;
		end else begin
			hit_s1 <= hit;
			hit_s2 <= hit_s1;
		end
	end
	always_ff @(posedge clk) begin
		st_s1 <= stereo_q[ti];
		g_s1  <= (17'(gain_q[ti]) > mtam_pkg::UNITY) ? mtam_pkg::UNITY : 17'(gain_q[ti]);
		st_s2 <= st_s1;
		pl_s2 <= 33'($signed(ram_rd[15:0])) * $signed({1'b0, g_s1});
		pr_s2 <= 33'($signed(ram_rd[31:16])) * $signed({1'b0, g_s1});
	end

	assign c0.en = hit_s2;
	assign c0.stereo = st_s2;
	assign c0.l = 17'(pl_s2 >>> 15);
	assign c0.r = 17'(pr_s2 >>> 15);
	assign cc[0] = c0;
	assign clr = acc && in_data.opcode == mtam_pkg::OP_RENDER;

	// channel cell chain
	for (genvar k = 0; k < M; k++) begin : g_cell
		mtam_cell u_cell (
			.clk(clk), .arst_n(arst_n), .clr(clr), .chan(mtam_pkg::CW'(k)),
			.nch(nch), .cin(cc[k]), .cout(cc[k+1]), .sum(sums[k])
		);
	end

	// saturate and present the current channel
	logic signed [mtam_pkg::ACCW-1:0] s;
	always_comb begin
		s = sums[oc_q];
		out_valid = (state_q == S_OUT);
		out_data.channel_index = 3'(oc_q);
		if (s > 20'sd32767) out_data.mixed_sample = 16'sh7fff;
		else if (s < -20'sd32768) out_data.mixed_sample = 16'sh8000;
		else out_data.mixed_sample = 16'(s);
		out_data.last = (mtam_pkg::NCW'(oc_q) + 1'b1 == nch);
		out_data.playing_mask = 4'(play_q);
	end
endmodule

// File: design/mtam_checker.sv
// ----------------------------------------------------------------------------
// mtam_checker: port-level checks of the mixer
// Handshake stability and frame framing on the result channel.
// ----------------------------------------------------------------------------
module mtam_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input mtam_pkg::res_t out_data
);
	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// no new request while a frame is being delivered
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request taken during frame output");

	// channel index advances within a frame
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |=>
		out_valid && out_data.channel_index == $past(out_data.channel_index) + 3'd1)
		else $error("channel sequence broken");

	// a frame starts at channel zero
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> out_data.channel_index == 3'd0)
		else $error("frame not started at channel zero");
endmodule

bind multitrack_audio_mixer_top mtam_checker u_mtam_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .out_data(out_data)
);
